[rtl/lru_object_cache_directory_defines.svh]
// assertion macros shared by the lru cache directory checker
`ifndef LRU_OBJECT_CACHE_DIRECTORY_DEFINES_SVH
`define LRU_OBJECT_CACHE_DIRECTORY_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define LRUCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// clocked assertion that also holds across reset
`define LRUCD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/lrucd_pkg.sv]
// shared constants, types and helpers of the lru cache directory
package lrucd_pkg;

    localparam int unsigned MAX_SLOTS = 16;
    localparam int unsigned KEY_BITS  = 64;

    localparam int unsigned IN_KEY_W = 64;
    localparam int unsigned SIZE_W   = 20;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned CFG_W    = 5;

    localparam int unsigned IDX_W  = $clog2(MAX_SLOTS);
    localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int unsigned RANK_W = IDX_W;
    localparam int unsigned ENT_W  = KEY_BITS + SIZE_W;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [RANK_W-1:0] rank_t;

    localparam cnt_t SLOT_COUNT = cnt_t'(MAX_SLOTS);
    localparam cnt_t CNT_ONE    = cnt_t'(1);
    localparam idx_t LAST_IDX   = idx_t'(MAX_SLOTS - 1);

    typedef struct packed {
        logic rd_en;
        idx_t rd_addr;
        logic wr_en;
        idx_t wr_addr;
    } ram_req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] found_size;
        logic              evicted;
    } result_t;

    // zero acts as one, anything above the slot count as the slot count
    function automatic cnt_t slots_in_use(input logic [CFG_W-1:0] active);
        int unsigned v;
        v = 32'(active);
        if (v == 0) begin
            v = 1;
        end
        if (v > MAX_SLOTS) begin
            v = MAX_SLOTS;
        end
        return cnt_t'(v);
    endfunction

endpackage

[rtl/lrucd_ram.sv]
// generic simple dual port ram with registered read
module lrucd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/lrucd_ctrl.sv]
// sequencer: slot scan, entry fill and recency update over the two rams
module lrucd_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_op,
    input  logic [lrucd_pkg::IN_KEY_W-1:0]     s_key,
    input  logic [lrucd_pkg::SIZE_W-1:0]       s_object_size,
    input  logic [lrucd_pkg::CFG_W-1:0]        active_slots,
    output lrucd_pkg::ram_req_t                ent_req,
    output logic [lrucd_pkg::ENT_W-1:0]        ent_wdata,
    input  logic [lrucd_pkg::ENT_W-1:0]        ent_rdata,
    output lrucd_pkg::ram_req_t                rank_req,
    output lrucd_pkg::rank_t                   rank_wdata,
    input  lrucd_pkg::rank_t                   rank_rdata,
    output logic                               res_valid,
    input  logic                               res_ready,
    output lrucd_pkg::result_t                 res
);
    import lrucd_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_RESOLVE = 3'd2;
    localparam logic [2:0] ST_TOUCH   = 3'd3;
    localparam logic [2:0] ST_FINISH  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic                op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    cnt_t                n_reg, n_next;
    cnt_t                iss_reg, iss_next;
    logic                rd_vld_reg, rd_vld_next;
    idx_t                rd_idx_reg, rd_idx_next;
    logic                found_reg, found_next;
    idx_t                sel_reg, sel_next;
    rank_t               sel_rank_reg, sel_rank_next;
    logic [SIZE_W-1:0]   fsize_reg, fsize_next;
    logic                have_reg, have_next;
    rank_t               best_reg, best_next;
    idx_t                vic_reg, vic_next;
    logic [MAX_SLOTS-1:0] valid_reg, valid_next;
    cnt_t                vcount_reg, vcount_next;
    idx_t                tgt_reg, tgt_next;
    rank_t               tgt_rank_reg, tgt_rank_next;
    result_t             res_reg, res_next;

    logic                rd_slot_valid;
    rank_t               rd_rank;
    logic [KEY_BITS-1:0] rd_key;
    logic [SIZE_W-1:0]   rd_size;
    idx_t                ins_slot;

    // a slot that was never filled reads as rank zero
    assign rd_slot_valid = valid_reg[rd_idx_reg];
    assign rd_rank       = rd_slot_valid ? rank_rdata : '0;
    assign rd_key        = ent_rdata[ENT_W-1 -: KEY_BITS];
    assign rd_size       = ent_rdata[SIZE_W-1:0];
    assign ins_slot      = found_reg ? sel_reg : vic_reg;

    assign ent_wdata = {key_reg, size_reg};
    assign res       = res_reg;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        size_next     = size_reg;
        n_next        = n_reg;
        iss_next      = iss_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        found_next    = found_reg;
        sel_next      = sel_reg;
        sel_rank_next = sel_rank_reg;
        fsize_next    = fsize_reg;
        have_next     = have_reg;
        best_next     = best_reg;
        vic_next      = vic_reg;
        valid_next    = valid_reg;
        vcount_next   = vcount_reg;
        tgt_next      = tgt_reg;
        tgt_rank_next = tgt_rank_reg;
        res_next      = res_reg;
        ent_req       = '0;
        rank_req      = '0;
        rank_wdata    = rd_rank;
        s_ready       = 1'b0;
        res_valid     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_op;
                    key_next   = s_key[KEY_BITS-1:0];
                    size_next  = s_object_size;
                    n_next     = slots_in_use(active_slots);
                    iss_next   = '0;
                    found_next = 1'b0;
                    have_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (iss_reg < n_reg) begin
                    ent_req.rd_en    = 1'b1;
                    ent_req.rd_addr  = iss_reg[IDX_W-1:0];
                    rank_req.rd_en   = 1'b1;
                    rank_req.rd_addr = iss_reg[IDX_W-1:0];
                    rd_vld_next      = 1'b1;
                    rd_idx_next      = iss_reg[IDX_W-1:0];
                    iss_next         = iss_reg + CNT_ONE;
                end
                if (rd_vld_reg) begin
                    if (op_reg == OP_LOOKUP) begin
                        if (rd_slot_valid && rd_key == key_reg && !found_reg) begin
                            found_next    = 1'b1;
                            sel_next      = rd_idx_reg;
                            sel_rank_next = rd_rank;
                            fsize_next    = rd_size;
                        end
                    end else begin
                        if (!rd_slot_valid && !found_reg) begin
                            found_next = 1'b1;
                            sel_next   = rd_idx_reg;
                        end
                        if (!have_reg || rd_rank > best_reg) begin
                            have_next = 1'b1;
                            best_next = rd_rank;
                            vic_next  = rd_idx_reg;
                        end
                    end
                    if (cnt_t'(rd_idx_reg) + CNT_ONE == n_reg) begin
                        state_next = ST_RESOLVE;
                    end
                end
            end
            ST_RESOLVE: begin
                iss_next = '0;
                if (op_reg == OP_LOOKUP) begin
                    tgt_next      = sel_reg;
                    tgt_rank_next = sel_rank_reg;
                    if (found_reg) begin
                        res_next.hit        = 1'b1;
                        res_next.slot       = SLOT_W'(sel_reg);
                        res_next.found_size = fsize_reg;
                        res_next.evicted    = 1'b0;
                        state_next          = ST_TOUCH;
                    end else begin
                        res_next   = '0;
                        state_next = ST_FINISH;
                    end
                end else begin
                    // fill an empty slot at the oldest rank, else replace the victim
                    ent_req.wr_en       = 1'b1;
                    ent_req.wr_addr     = ins_slot;
                    tgt_next            = ins_slot;
                    tgt_rank_next       = found_reg ? rank_t'(vcount_reg) : best_reg;
                    valid_next[ins_slot] = 1'b1;
                    if (found_reg) begin
                        vcount_next = vcount_reg + CNT_ONE;
                    end
                    res_next.hit        = 1'b0;
                    res_next.slot       = SLOT_W'(ins_slot);
                    res_next.found_size = '0;
                    res_next.evicted    = !found_reg;
                    state_next          = ST_TOUCH;
                end
            end
            ST_TOUCH: begin
                // read slot i while slot i-1 is written back, never the same entry
                if (iss_reg < SLOT_COUNT) begin
                    rank_req.rd_en   = 1'b1;
                    rank_req.rd_addr = iss_reg[IDX_W-1:0];
                    rd_vld_next      = 1'b1;
                    rd_idx_next      = iss_reg[IDX_W-1:0];
                    iss_next         = iss_reg + CNT_ONE;
                end
                if (rd_vld_reg) begin
                    rank_req.wr_en   = 1'b1;
                    rank_req.wr_addr = rd_idx_reg;
                    if (rd_idx_reg == tgt_reg) begin
                        rank_wdata = '0;
                    end else if (rd_slot_valid && rd_rank < tgt_rank_reg) begin
                        rank_wdata = rd_rank + rank_t'(1);
                    end else begin
                        rank_wdata = rd_rank;
                    end
                    if (rd_idx_reg == LAST_IDX) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
            valid_reg  <= '0;
            vcount_reg <= '0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
            valid_reg  <= valid_next;
            vcount_reg <= vcount_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        size_reg     <= size_next;
        n_reg        <= n_next;
        iss_reg      <= iss_next;
        rd_idx_reg   <= rd_idx_next;
        found_reg    <= found_next;
        sel_reg      <= sel_next;
        sel_rank_reg <= sel_rank_next;
        fsize_reg    <= fsize_next;
        have_reg     <= have_next;
        best_reg     <= best_next;
        vic_reg      <= vic_next;
        tgt_reg      <= tgt_next;
        tgt_rank_reg <= tgt_rank_next;
        res_reg      <= res_next;
    end

endmodule

[rtl/lru_object_cache_directory.sv]
// top level of the lru object cache directory
// Directory of a fully associative object cache with least-recently-used
// replacement. Each item is a lookup (s_op 0) or an insert (s_op 1) of a
// 64-bit key, and produces exactly one result item. Items are handled one at
// a time. The recency rank ram has a single read port, which is walked over the
// n active slots to search keys and find the oldest entry and then, for a
// lookup that hits or any insert, over every slot to age the ranks. A
// finished result waits in the output register, so the next item is taken
// and worked on while the previous result is still pending. The user must
// write the active_slots register through cfg_wr_en / cfg_wr_data only while
// the block is idle; the block itself does not enforce this. It resets to 16,
// zero behaves as one and values above the slot count behave as the slot
// count. There is no clearing pass after reset: reset clears the slot valid
// flags directly.
module lru_object_cache_directory (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [lrucd_pkg::CFG_W-1:0]     cfg_wr_data,
    // request items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [lrucd_pkg::IN_KEY_W-1:0]  s_key,
    input  logic [lrucd_pkg::SIZE_W-1:0]    s_object_size,
    // result items
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_hit,
    output logic [lrucd_pkg::SLOT_W-1:0]    m_slot,
    output logic [lrucd_pkg::SIZE_W-1:0]    m_found_size,
    output logic                            m_evicted
);
    import lrucd_pkg::*;

    logic [CFG_W-1:0] active_slots_reg;

    ram_req_t          ent_req;
    logic [ENT_W-1:0]  ent_wdata;
    logic [ENT_W-1:0]  ent_rdata;
    ram_req_t          rank_req;
    rank_t             rank_wdata;
    rank_t             rank_rdata;

    logic              res_valid;
    logic              res_ready;
    result_t           res;

    logic              m_valid_reg;
    result_t           out_reg;

    // slot count register, to be only written between items by the user; the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_slots_reg <= ACTIVE_RESET;
        end else if (cfg_wr_en) begin
            active_slots_reg <= cfg_wr_data;
        end
    end

    // key and object size of every slot, one entry per slot
    lrucd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SLOTS)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ent_req.wr_en),
        .wr_addr (ent_req.wr_addr),
        .wr_data (ent_wdata),
        .rd_en   (ent_req.rd_en),
        .rd_addr (ent_req.rd_addr),
        .rd_data (ent_rdata)
    );

    // recency rank of every slot, 0 is most recent
    lrucd_ram #(
        .WIDTH (RANK_W),
        .DEPTH (MAX_SLOTS)
    ) u_rank_ram (
        .aclk    (aclk),
        .wr_en   (rank_req.wr_en),
        .wr_addr (rank_req.wr_addr),
        .wr_data (rank_wdata),
        .rd_en   (rank_req.rd_en),
        .rd_addr (rank_req.rd_addr),
        .rd_data (rank_rdata)
    );

    // search, fill and recency sequencer, also holds the slot valid flags
    lrucd_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_key         (s_key),
        .s_object_size (s_object_size),
        .active_slots  (active_slots_reg),
        .ent_req       (ent_req),
        .ent_wdata     (ent_wdata),
        .ent_rdata     (ent_rdata),
        .rank_req      (rank_req),
        .rank_wdata    (rank_wdata),
        .rank_rdata    (rank_rdata),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    // output register: a new result loads when the slot is empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = out_reg.hit;
    assign m_slot       = out_reg.slot;
    assign m_found_size = out_reg.found_size;
    assign m_evicted    = out_reg.evicted;

endmodule

[rtl/lrucd_chk.sv]
// port level assertions for the lru cache directory, bound to the top level
`include "lru_object_cache_directory_defines.svh"

module lrucd_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_hit,
    input logic [lrucd_pkg::SLOT_W-1:0]    m_slot,
    input logic [lrucd_pkg::SIZE_W-1:0]    m_found_size,
    input logic                            m_evicted
);

    // everything the result channel shows, valid included
    logic [lrucd_pkg::SLOT_W + lrucd_pkg::SIZE_W + 2:0] res_bits;

    assign res_bits = {m_valid, m_hit, m_slot, m_found_size, m_evicted};

    // a waiting result holds still
    `LRUCD_ASSERT(a_res_hold, m_valid && !m_ready |=> $stable(res_bits), "stalled result changed")

    // a hit and an eviction never show together (only an insert evicts, and an insert never hits)
    `LRUCD_ASSERT(a_hit_evict, m_valid |-> !(m_hit && m_evicted), "hit and eviction together")

    // a size is only returned with a hit
    `LRUCD_ASSERT(a_size_on_hit, m_valid && !m_hit |-> m_found_size == '0, "size without hit")

    // one item at a time: nothing taken in the cycle after an acceptance
    `LRUCD_ASSERT(a_one_item, s_valid && s_ready |=> !s_ready, "request taken back to back")

    // reset empties the output register
    `LRUCD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind lru_object_cache_directory lrucd_chk u_lrucd_chk (.*);

[bench/tb_lru_object_cache_directory.sv]
// self-checking testbench of the lru object cache directory
`timescale 1ns / 100ps

module tb_lru_object_cache_directory;
    import lrucd_pkg::*;

    // generous watchdog: several times what the slowest legal run needs
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned PHASE_ITEMS  = 200;
    localparam int unsigned POOL_DEPTH   = 20;
    localparam int unsigned NUM_PHASES   = 8;

    // one request item as the sender presents it
    typedef struct packed {
        logic              op;
        logic [63:0]       key;
        logic [SIZE_W-1:0] size;
    } cache_req_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data   = '0;
    logic                s_valid       = 1'b0;
    logic                s_op          = OP_LOOKUP;
    logic [IN_KEY_W-1:0] s_key         = '0;
    logic [SIZE_W-1:0]   s_object_size = '0;
    logic                m_ready       = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic                m_hit;
    logic [SLOT_W-1:0]   m_slot;
    logic [SIZE_W-1:0]   m_found_size;
    logic                m_evicted;

    lru_object_cache_directory dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_key         (s_key),
        .s_object_size (s_object_size),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_slot        (m_slot),
        .m_found_size  (m_found_size),
        .m_evicted     (m_evicted)
    );

    // 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // directory shadow: keys, sizes, valid marks and recency ranks
    // ------------------------------------------------------------------
    logic [63:0]       dir_key   [MAX_SLOTS];
    logic [SIZE_W-1:0] dir_size  [MAX_SLOTS];
    logic              dir_valid [MAX_SLOTS];
    rank_t             dir_rank  [MAX_SLOTS];
    logic [CFG_W-1:0]  active_cfg = ACTIVE_RESET;

    initial begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            dir_valid[i] = 1'b0;
            dir_rank[i]  = '0;
            dir_key[i]   = '0;
            dir_size[i]  = '0;
        end
    end

    // zero behaves as one, anything past the slot count as the full count
    function automatic int effective_slots(input logic [CFG_W-1:0] cfg);
        int n;
        n = int'(cfg);
        if (n == 0) begin
            n = 1;
        end
        if (n > MAX_SLOTS) begin
            n = MAX_SLOTS;
        end
        return n;
    endfunction

    // slot s becomes most recent; valid slots that were more recent age by one
    // (inactive slots age too, they keep their place in the order)
    function automatic void make_most_recent(input int s);
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (i != s && dir_valid[i] && dir_rank[i] < dir_rank[s]) begin
                dir_rank[i] = dir_rank[i] + 1'b1;
            end
        end
        dir_rank[s] = '0;
    endfunction

    // apply one request to the shadow directory and return the result item
    function automatic result_t lru_access(input cache_req_t r);
        result_t res;
        int      n;
        int      s;
        int      valid_count;
        bit      found;
        rank_t   oldest;
        res   = '0;
        n     = effective_slots(active_cfg);
        found = 1'b0;
        s     = 0;
        if (r.op == OP_LOOKUP) begin
            // lowest matching valid slot wins; a miss leaves everything zero
            for (int i = 0; i < n; i++) begin
                if (!found && dir_valid[i] && dir_key[i] == r.key) begin
                    found          = 1'b1;
                    res.hit        = 1'b1;
                    res.slot       = SLOT_W'(i);
                    res.found_size = dir_size[i];
                    make_most_recent(i);
                end
            end
        end else begin
            // lowest empty active slot first
            for (int i = 0; i < n; i++) begin
                if (!found && !dir_valid[i]) begin
                    found = 1'b1;
                    s     = i;
                end
            end
            if (!found) begin
                // cache full: evict the oldest active slot, lowest on a tie
                oldest = dir_rank[0];
                s      = 0;
                for (int i = 1; i < n; i++) begin
                    if (dir_rank[i] > oldest) begin
                        oldest = dir_rank[i];
                        s      = i;
                    end
                end
                res.evicted = 1'b1;
            end else begin
                // a fresh entry starts as the oldest so that the touch ages all
                valid_count = 0;
                for (int i = 0; i < MAX_SLOTS; i++) begin
                    if (dir_valid[i]) begin
                        valid_count++;
                    end
                end
                dir_rank[s] = rank_t'(valid_count);
            end
            dir_key[s]   = r.key;
            dir_size[s]  = r.size;
            dir_valid[s] = 1'b1;
            make_most_recent(s);
            res.slot = SLOT_W'(s);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // shared bookkeeping between stimulus, driver and monitor
    // ------------------------------------------------------------------
    cache_req_t  pending_items[$];
    result_t     expected_results[$];
    cache_req_t  offered_item;
    result_t     oldest_result;
    int unsigned items_issued     = 0;
    int unsigned results_checked  = 0;
    int unsigned mismatches       = 0;
    int unsigned cycle_count      = 0;
    int unsigned long_holds_asked = 0;
    int unsigned long_holds_done  = 0;
    logic        quiet_tail       = 1'b0;
    int unsigned send_gap         = 0;
    int unsigned recv_gap         = 0;
    int unsigned hold_left        = 0;

    // ------------------------------------------------------------------
    // driver: presents queued items, idles in short random bursts
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // accepted item: predict its result now, in acceptance order
            if (s_valid && s_ready) begin
                expected_results.push_back(lru_access(offered_item));
            end
            // only move on once the current item is gone (or none is up)
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                    // start an idle burst of random length, this cycle included
                    send_gap = $urandom_range(0, 2);
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    offered_item = pending_items.pop_front();
                    s_valid       <= 1'b1;
                    s_op          <= offered_item.op;
                    s_key         <= offered_item.key;
                    s_object_size <= offered_item.size;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks results in order, stalls in bursts, and holds off
    // for a long stretch on request so that the block backs up
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result item: hit %0b slot %0d size %0d evicted %0b",
                             $time, m_hit, m_slot, m_found_size, m_evicted);
                    mismatches++;
                end else begin
                    oldest_result = expected_results.pop_front();
                    results_checked++;
                    if (m_hit !== oldest_result.hit) begin
                        $display("%0t: hit mismatch: expected %0b, actual %0b",
                                 $time, oldest_result.hit, m_hit);
                        mismatches++;
                    end
                    if (m_slot !== oldest_result.slot) begin
                        $display("%0t: slot mismatch: expected %0d, actual %0d",
                                 $time, oldest_result.slot, m_slot);
                        mismatches++;
                    end
                    if (m_found_size !== oldest_result.found_size) begin
                        $display("%0t: found_size mismatch: expected %0d, actual %0d",
                                 $time, oldest_result.found_size, m_found_size);
                        mismatches++;
                    end
                    if (m_evicted !== oldest_result.evicted) begin
                        $display("%0t: evicted mismatch: expected %0b, actual %0b",
                                 $time, oldest_result.evicted, m_evicted);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (long_holds_asked > long_holds_done) begin
                long_holds_done++;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                recv_gap = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(input logic op, input logic [63:0] key,
                              input logic [SIZE_W-1:0] size);
        cache_req_t r;
        r.op   = op;
        r.key  = key;
        r.size = size;
        pending_items.push_back(r);
        items_issued++;
    endtask

    // sender stops until every issued item has had its result checked
    task automatic wait_drained();
        while (results_checked != items_issued) begin
            @(posedge aclk);
        end
    endtask

    // register write while idle; the shadow follows the same edge
    task automatic write_active(input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        active_cfg = value;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return SIZE_W'($urandom);
        endcase
    endfunction

    // active counts per phase: extremes, out-of-range values and shrinks
    // that leave valid entries stranded above the count
    logic [CFG_W-1:0] phase_cfg [NUM_PHASES] = '{
        5'd0, 5'd31, 5'd1, 5'd5, 5'd16, 5'd2, 5'd9, 5'd16
    };

    initial begin
        logic [63:0] key_pool [POOL_DEPTH];
        int          pool_span;
        logic        op;
        logic [63:0] key;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at the reset count of 16
        // empty cache, then zero-size and all-ones entries
        queue_item(OP_LOOKUP, 64'h0, '1);
        queue_item(OP_INSERT, 64'h0, '0);
        queue_item(OP_INSERT, '1, '1);
        queue_item(OP_LOOKUP, 64'h0, '0);
        queue_item(OP_LOOKUP, '1, '0);
        // duplicate key: lookup reports the lowest slot
        queue_item(OP_INSERT, 64'h0, 20'h5);
        queue_item(OP_LOOKUP, 64'h0, '0);
        // fill every remaining slot with alternating bit patterns
        for (int i = 3; i < MAX_SLOTS; i++) begin
            queue_item(OP_INSERT, (i % 2 != 0) ? 64'hAAAA_AAAA_AAAA_AAAA ^ 64'(i)
                                               : 64'h5555_5555_5555_5555 ^ 64'(i),
                       SIZE_W'(i * 4099));
        end
        // full cache: inserts now evict the least recent entries
        queue_item(OP_INSERT, 64'h8000_0000_0000_0001, 20'h80001);
        queue_item(OP_INSERT, 64'h0123_4567_89AB_CDEF, 20'h7FFFE);
        queue_item(OP_LOOKUP, '1, '0);
        queue_item(OP_LOOKUP, 64'h8000_0000_0000_0001, '0);
        wait_drained();

        // random phases, one active count each
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_active(phase_cfg[p]);
            if (p == 3) begin
                // receiver holds off while the sender keeps offering items
                long_holds_asked <= long_holds_asked + 1;
            end
            if (p == NUM_PHASES - 1) begin
                quiet_tail <= 1'b1;
            end
            // small key pool so that lookups hit often, sized to the count
            for (int i = 0; i < POOL_DEPTH; i++) begin
                key_pool[i] = {$urandom, $urandom};
            end
            pool_span = 2 * effective_slots(phase_cfg[p]) + 1;
            if (pool_span > POOL_DEPTH - 1) begin
                pool_span = POOL_DEPTH - 1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                op = ($urandom_range(0, 1) != 0) ? OP_INSERT : OP_LOOKUP;
                if ($urandom_range(0, 7) == 0) begin
                    key = {$urandom, $urandom};
                end else begin
                    key = key_pool[$urandom_range(0, pool_span)];
                end
                queue_item(op, key, pick_size());
            end
            wait_drained();
        end

        // tail: let any stray result item show up before the verdict
        repeat (60) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
